// ===== rtl/core/bnpa_pkg.sv =====
// Package of shared types, constants and helper functions for the block and node pool allocator.
package bnpa_pkg;

  localparam int NUM_BLOCKS      = 64;
  localparam int BLOCK_BYTES     = 1024;
  localparam int NODES_PER_BLOCK = 16;
  localparam int REF_BYTES       = 4;
  localparam int NODE_TOTAL      = NUM_BLOCKS * NODES_PER_BLOCK;
  localparam int HALF            = NODES_PER_BLOCK / 2;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);
  localparam int NODE_W  = $clog2(NODE_TOTAL);
  localparam int K_W     = $clog2(NODES_PER_BLOCK);
  localparam int CNT_W   = $clog2(NODES_PER_BLOCK + 1);
  localparam int REQ_W   = 12;
  localparam int ALLOC_W = 14;

  localparam logic [7:0] HDR_RESET = 8'd32;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [BLK_W:0]    blink_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NODE_W:0]   link_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [K_W-1:0]    kidx_t;

  localparam blink_t BLK_NIL  = blink_t'(NUM_BLOCKS);
  localparam link_t  NODE_NIL = link_t'(NODE_TOTAL);

  // Pointer values left behind by carving block zero at reset.
  localparam node_t INIT_HEAD = node_t'(HALF);
  localparam node_t INIT_TAIL = (HALF + 1 <= NODES_PER_BLOCK - 1) ?
                                node_t'(NODES_PER_BLOCK - 1) : node_t'(0);

  typedef enum logic [1:0] {
    CMD_BLOCK_ALLOC = 2'd0,
    CMD_BLOCK_FREE  = 2'd1,
    CMD_NODE_ALLOC  = 2'd2,
    CMD_NODE_FREE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_BLOCK  = 2'd2,
    STAT_NO_NODE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_BPOP, S_NPOP, S_CPOP,
    S_CARVE, S_CEND, S_NFREE, S_NTAIL, S_DONE
  } state_t;

  typedef struct packed {
    status_t    status;
    node_t      index;
    logic [7:0] max_refs;
  } res_t;

  typedef struct packed {
    logic  we;
    node_t waddr;
    link_t wdata;
    node_t raddr;
  } nl_req_t;

  typedef struct packed {
    logic   link_we;
    blk_t   link_waddr;
    blink_t link_wdata;
    blk_t   link_raddr;
    logic   cnt_we;
    blk_t   cnt_waddr;
    cnt_t   cnt_wdata;
    blk_t   cnt_raddr;
  } bl_req_t;

  // Node link contents after block zero has been carved.
  function automatic link_t init_node_link(node_t i);
    link_t v;
    v = NODE_NIL;
    if (i == node_t'(0)) begin
      if (HALF + 1 <= NODES_PER_BLOCK - 1) v = link_t'(HALF + 1);
    end else if (i <= node_t'(HALF)) begin
      v = link_t'(i) - link_t'(1);
    end else if (i < node_t'(NODES_PER_BLOCK - 1)) begin
      v = link_t'(i) + link_t'(1);
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/bnpa_node_ram.sv =====
// Node link memory with one write port and one registered read port.
module bnpa_node_ram
  import bnpa_pkg::*;
(
  input  logic    clk,
  input  nl_req_t req,
  output link_t   rdata
);

  link_t mem [NODE_TOTAL];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/core/bnpa_block_ram.sv =====
// Block link memory and per-block free node count memory, each with a registered read.
module bnpa_block_ram
  import bnpa_pkg::*;
(
  input  logic    clk,
  input  bl_req_t req,
  output blink_t  link_rdata,
  output cnt_t    cnt_rdata
);

  blink_t link_mem [NUM_BLOCKS];
  cnt_t   cnt_mem  [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    link_rdata <= link_mem[req.link_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
    end
    cnt_rdata <= cnt_mem[req.cnt_raddr];
  end

endmodule

// ===== rtl/core/bnpa_ctrl.sv =====
// Sequencer that reads, modifies and writes back the allocator lists for one item at a time.
module bnpa_ctrl
  import bnpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [7:0]        ref_count,
  input  blk_t              block_index,
  input  node_t             node_index,
  input  logic [7:0]        hdr,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output nl_req_t           nl_req,
  input  link_t             nl_rdata,
  output bl_req_t           bl_req,
  input  blink_t            bl_link_rdata,
  input  cnt_t              bl_cnt_rdata
);

  state_t state, state_next;

  cmd_t              cmd;
  logic [REQ_W-1:0]  req;
  logic [7:0]        refc;
  blk_t              blk_in;
  node_t             nidx;
  node_t             head;
  node_t             tail;
  blink_t            bh;
  blk_t              blk;
  kidx_t             k;
  logic              phase;
  node_t             icnt;

  // Block sizing arithmetic.
  localparam logic signed [ALLOC_W-1:0] BLOCK_BYTES_S = ALLOC_W'(BLOCK_BYTES);
  logic signed [ALLOC_W-1:0] hdr_s, req_s, rb_s, need, mnum;
  logic [ALLOC_W-1:0]        mq;
  logic                      is_fill, too_large, too_small;
  logic [7:0]                refs;
  logic                      pop_ok, bh_nil, carve_last;
  node_t                     carve_node;
  res_t                      dec_res;

  always_comb begin
    hdr_s     = $signed(ALLOC_W'(hdr));
    req_s     = ALLOC_W'($signed(req));
    rb_s      = $signed(ALLOC_W'(refc * REF_BYTES));
    need      = hdr_s + req_s + rb_s;
    mnum      = BLOCK_BYTES_S - hdr_s - req_s;
    mq        = ALLOC_W'($unsigned(mnum) / REF_BYTES);
    is_fill   = (req == {REQ_W{1'b1}});
    too_large = !is_fill && (need > BLOCK_BYTES_S);
    too_small = !is_fill && (need < 0);
    if (is_fill) begin
      refs = refc;
    end else if (mq > ALLOC_W'(255)) begin
      refs = 8'hFF;
    end else begin
      refs = mq[7:0];
    end
    pop_ok     = (head != tail) && (nl_rdata < NODE_NIL);
    bh_nil     = (bh >= BLK_NIL);
    carve_node = {blk, k};
    carve_last = (k == kidx_t'(NODES_PER_BLOCK - 1)) && ((k <= kidx_t'(HALF)) || phase);
  end

  // Result of the decode cycle; a node alloc fills its index in later.
  always_comb begin
    dec_res = '{STAT_OK, node_t'(0), 8'd0};
    if (state == S_DECODE) begin
      unique case (cmd)
        CMD_BLOCK_ALLOC: begin
          if (too_large) begin
            dec_res.status = STAT_TOO_LARGE;
          end else if (too_small || bh_nil) begin
            dec_res.status = STAT_NO_BLOCK;
          end else begin
            dec_res.index    = node_t'(bh[BLK_W-1:0]);
            dec_res.max_refs = refs;
          end
        end
        CMD_BLOCK_FREE: dec_res.index = node_t'(blk_in);
        CMD_NODE_ALLOC: begin
        end
        CMD_NODE_FREE:  dec_res.index = nidx;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (icnt == node_t'(NODE_TOTAL - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (cmd)
          CMD_BLOCK_ALLOC: state_next = (too_large || too_small || bh_nil) ? S_DONE : S_BPOP;
          CMD_BLOCK_FREE:  state_next = S_DONE;
          CMD_NODE_ALLOC:  state_next = S_NPOP;
          CMD_NODE_FREE:   state_next = S_NFREE;
        endcase
      end
      S_BPOP:   state_next = S_DONE;
      S_NPOP:   state_next = (pop_ok || bh_nil) ? S_DONE : S_CPOP;
      S_CPOP:   state_next = S_CARVE;
      S_CARVE:  if (carve_last) state_next = S_CEND;
      S_CEND:   state_next = S_DONE;
      S_NFREE:  state_next = (bl_cnt_rdata > cnt_t'(HALF)) ? S_NTAIL : S_DONE;
      S_NTAIL:  state_next = S_DONE;
      S_DONE:   if (res_ready) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    res_valid = (state == S_DONE);

    nl_req       = '0;
    nl_req.raddr = head;
    bl_req            = '0;
    bl_req.link_raddr = bh[BLK_W-1:0];
    bl_req.cnt_raddr  = (cmd == CMD_NODE_ALLOC) ? head[NODE_W-1:K_W] : nidx[NODE_W-1:K_W];

    unique case (state)
      S_INIT: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = icnt;
        nl_req.wdata = init_node_link(icnt);
        if (icnt < node_t'(NUM_BLOCKS)) begin
          bl_req.link_we    = 1'b1;
          bl_req.link_waddr = icnt[BLK_W-1:0];
          bl_req.link_wdata = blink_t'(icnt) + blink_t'(1);
          bl_req.cnt_we     = 1'b1;
          bl_req.cnt_waddr  = icnt[BLK_W-1:0];
          bl_req.cnt_wdata  = (icnt == node_t'(0)) ? cnt_t'(NODES_PER_BLOCK) : cnt_t'(0);
        end
      end
      S_DECODE: begin
        if (cmd == CMD_BLOCK_ALLOC && !too_large && !too_small && !bh_nil) begin
          bl_req.cnt_we    = 1'b1;
          bl_req.cnt_waddr = bh[BLK_W-1:0];
        end else if (cmd == CMD_BLOCK_FREE) begin
          bl_req.cnt_we     = 1'b1;
          bl_req.cnt_waddr  = blk_in;
          bl_req.link_we    = 1'b1;
          bl_req.link_waddr = blk_in;
          bl_req.link_wdata = bh;
        end
      end
      S_NPOP: begin
        if (pop_ok && bl_cnt_rdata != cnt_t'(0)) begin
          bl_req.cnt_we    = 1'b1;
          bl_req.cnt_waddr = head[NODE_W-1:K_W];
          bl_req.cnt_wdata = bl_cnt_rdata - cnt_t'(1);
        end
      end
      S_CPOP: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = {blk, kidx_t'(0)};
        nl_req.wdata = NODE_NIL;
      end
      S_CARVE: begin
        nl_req.we = 1'b1;
        if (k <= kidx_t'(HALF)) begin
          nl_req.waddr = carve_node;
          nl_req.wdata = link_t'(head);
        end else if (!phase) begin
          nl_req.waddr = carve_node;
          nl_req.wdata = NODE_NIL;
        end else begin
          nl_req.waddr = tail;
          nl_req.wdata = link_t'(carve_node);
        end
      end
      S_CEND: begin
        bl_req.cnt_we    = 1'b1;
        bl_req.cnt_waddr = blk;
        bl_req.cnt_wdata = cnt_t'(NODES_PER_BLOCK - 1);
      end
      S_NFREE: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = nidx;
        nl_req.wdata = (bl_cnt_rdata > cnt_t'(HALF)) ? NODE_NIL : link_t'(head);
        if (bl_cnt_rdata < cnt_t'(NODES_PER_BLOCK)) begin
          bl_req.cnt_we    = 1'b1;
          bl_req.cnt_waddr = nidx[NODE_W-1:K_W];
          bl_req.cnt_wdata = bl_cnt_rdata + cnt_t'(1);
        end
      end
      S_NTAIL: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = tail;
        nl_req.wdata = link_t'(nidx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      icnt  <= '0;
      head  <= INIT_HEAD;
      tail  <= INIT_TAIL;
      bh    <= blink_t'(1);
      k     <= '0;
      phase <= 1'b0;
      cmd   <= CMD_BLOCK_ALLOC;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT: icnt <= icnt + node_t'(1);
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= cmd_t'(command);
            req    <= request_bytes;
            refc   <= ref_count;
            blk_in <= block_index;
            nidx   <= node_index;
          end
        end
        S_DECODE: begin
          res <= dec_res;
          if (cmd == CMD_BLOCK_FREE) bh <= blink_t'(blk_in);
        end
        S_BPOP: bh <= bl_link_rdata;
        S_NPOP: begin
          if (pop_ok) begin
            head      <= nl_rdata[NODE_W-1:0];
            res.index <= head;
          end else if (bh_nil) begin
            res.status <= STAT_NO_NODE;
          end else begin
            blk <= bh[BLK_W-1:0];
          end
        end
        S_CPOP: begin
          bh    <= bl_link_rdata;
          k     <= kidx_t'(1);
          phase <= 1'b0;
        end
        S_CARVE: begin
          if (k <= kidx_t'(HALF)) begin
            head <= carve_node;
            k    <= k + kidx_t'(1);
          end else if (!phase) begin
            phase <= 1'b1;
          end else begin
            tail  <= carve_node;
            phase <= 1'b0;
            k     <= k + kidx_t'(1);
          end
        end
        S_CEND: res.index <= {blk, kidx_t'(0)};
        S_NFREE: begin
          if (bl_cnt_rdata <= cnt_t'(HALF)) head <= nidx;
        end
        S_NTAIL: tail <= nidx;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/block_and_node_pool_allocator.sv =====
// Top level of the block and node pool allocator: memories, sequencer, register and result stage.
//
// The allocator keeps a LIFO free list of 64 blocks of 1024 bytes and a queue of free nodes,
// 16 to a block, in synchronous memories. After reset a clearing pass writes the link memories
// and the free counts (block zero already carved) while in_stall stays high; the configuration
// port is open throughout. Each item then goes through a read, modify and write back sequence
// over the list memories: an accept, a decode, a memory read and a hand-over state. A block free
// and a block alloc that fails skip the memory read state, and a node free that goes to the tail
// of the queue adds a tail write state. A node alloc that finds the queue empty carves a fresh
// block by walking its nodes one link write per cycle. Results go into an output register, so
// the next item is taken while a result still waits on out_stall. Status 0 is ok, 1 request too
// large, 2 no free block and 3 no node; on an error index and max_refs are zero. Double frees
// are not checked.
module block_and_node_pool_allocator
  import bnpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       command,
  input  logic [11:0]      request_bytes,
  input  logic [7:0]       ref_count,
  input  logic [5:0]       block_index,
  input  logic [9:0]       node_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [9:0]       index,
  output logic [7:0]       max_refs,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);

  logic [7:0] header_bytes;
  nl_req_t    nl_req;
  link_t      nl_rdata;
  bl_req_t    bl_req;
  blink_t     bl_link_rdata;
  cnt_t       bl_cnt_rdata;
  logic       res_valid;
  logic       res_ready;
  res_t       res;
  res_t       out_res;

  // Header size register is always ready; the user must write it only while idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_bytes <= cfg_data;
    end
  end

  bnpa_node_ram u_node_ram (
    .clk   (clk),
    .req   (nl_req),
    .rdata (nl_rdata)
  );

  bnpa_block_ram u_block_ram (
    .clk        (clk),
    .req        (bl_req),
    .link_rdata (bl_link_rdata),
    .cnt_rdata  (bl_cnt_rdata)
  );

  bnpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .request_bytes (request_bytes),
    .ref_count     (ref_count),
    .block_index   (block_index),
    .node_index    (node_index),
    .hdr           (header_bytes),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .nl_req        (nl_req),
    .nl_rdata      (nl_rdata),
    .bl_req        (bl_req),
    .bl_link_rdata (bl_link_rdata),
    .bl_cnt_rdata  (bl_cnt_rdata)
  );

  // Output register: a finished item moves in when the register is empty or being emptied.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign status   = out_res.status;
  assign index    = out_res.index;
  assign max_refs = out_res.max_refs;

endmodule

// ===== rtl/core/bnpa_checker.sv =====
// Port-level checker for the block and node pool allocator, bound to the top level.
module bnpa_checker
  import bnpa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [9:0]  index,
  input logic [7:0]  max_refs
);

  // After reset the clearing pass runs and nothing is offered.
  a_reset_busy: assert property (@(posedge clk) rst |=> (in_stall && !out_valid))
    else $error("allocator not busy and empty after reset");

  // One item at a time: the block is busy in the cycle after an accept.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(index) && $stable(max_refs)))
    else $error("stalled result changed");

  // An error carries neither index nor reference slots.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> (index == 10'd0 && max_refs == 8'd0))
    else $error("error result with nonzero index or max_refs");

endmodule

bind block_and_node_pool_allocator bnpa_checker u_bnpa_checker (.*);
